>>> sv/segment_intersection_2d_top_defines.svh
// Assertion macros for the segment intersection block.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef SEGMENT_INTERSECTION_2D_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_2D_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SEGI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// next-cycle implication, checked out of reset
`define SEGI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

`endif

>>> sv/segi2d_pkg.sv
// Package for the segment intersection block: defaults and outcome codes.
// No dependencies.
`default_nettype none
package segi2d_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int XY_BITS        = 32;

  localparam logic [1:0] OUTC_HIT   = 2'd0;
  localparam logic [1:0] OUTC_BOX   = 2'd1;
  localparam logic [1:0] OUTC_DET   = 2'd2;
  localparam logic [1:0] OUTC_RANGE = 2'd3;
endpackage
`default_nettype wire

>>> sv/segment_intersection_2d_top.sv
// Segment intersection test with pipelined Cramer solve and bit-serial divide stages.
// Depends on segi2d_pkg and segment_intersection_2d_top_defines.svh.
//
// One segment pair enters per cycle while in_stall_o is low, and one result leaves
// per cycle while out_stall_i is low. The pipe has seven arithmetic stages (box
// test, products, determinant, sign fix, split multiply, dividend setup, final
// rounding) plus one restoring-divide stage per quotient bit for the two crossing
// coordinates, which run in parallel lanes. A two-entry output register with skid
// keeps in_stall_o registered; the pipe holds while the skid entry is full.
`default_nettype none
`include "segment_intersection_2d_top_defines.svh"
module segment_intersection_2d_top #(
  parameter int COORD_BITS = segi2d_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = segi2d_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [COORD_BITS-1:0]              seg1_start_x_i,
  input  wire logic [COORD_BITS-1:0]              seg1_start_y_i,
  input  wire logic [COORD_BITS-1:0]              seg1_end_x_i,
  input  wire logic [COORD_BITS-1:0]              seg1_end_y_i,
  input  wire logic [COORD_BITS-1:0]              seg2_start_x_i,
  input  wire logic [COORD_BITS-1:0]              seg2_start_y_i,
  input  wire logic [COORD_BITS-1:0]              seg2_end_x_i,
  input  wire logic [COORD_BITS-1:0]              seg2_end_y_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    hit_o,
  output logic [1:0]                              outcome_o,
  output logic [segi2d_pkg::XY_BITS-1:0]          cross_x_o,
  output logic [segi2d_pkg::XY_BITS-1:0]          cross_y_o
);
  import segi2d_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DW = C + 1;         // coordinate difference
  localparam int PW = 2 * DW;        // product of two differences
  localparam int NW = PW + 1;        // determinant and numerators
  localparam int RW = NW - 1;        // magnitude of determinant
  localparam int H  = C + 1;         // split point of the numerator multiply
  localparam int LW = C + H;         // partial product width
  localparam int MW = C + RW;        // full |a| * nt
  localparam int Q  = C + F;         // quotient bits
  localparam int SW = Q + 2;         // fixed-point sum
  localparam int OW = XY_BITS;

  typedef struct packed {
    logic [1:0]    outcome;
    logic [C-1:0]  ax;
    logic [C-1:0]  ay;
    logic          negx;
    logic          negy;
    logic [RW-1:0] den;
    logic [RW-1:0] remx;
    logic [RW-1:0] remy;
    logic [Q-1:0]  shx;
    logic [Q-1:0]  shy;
  } div_t;

  // one restoring step: returns {next remainder, next shift word}
  function automatic logic [RW+Q-1:0] div_step(input logic [RW-1:0] rem,
                                               input logic [Q-1:0] sh,
                                               input logic [RW-1:0] den);
    logic [RW:0] trial;
    logic        ge;
    logic [RW:0] nr;
    trial = {rem, sh[Q-1]};
    ge    = (trial >= {1'b0, den});
    nr    = ge ? (trial - {1'b0, den}) : trial;
    return {nr[RW-1:0], sh[Q-2:0], ge};
  endfunction

  logic en;
  logic skid_v_q;
  logic out_v_q;

  assign en         = ~skid_v_q;
  assign in_stall_o = skid_v_q;

  // valid bits for the fixed stages
  logic [5:0]  v_q;
  logic [Q:0]  dv_v_q;
  logic        fin_v_q;

  // stage 0: input capture
  logic [C-1:0] ax0_q, ay0_q, bx0_q, by0_q, cx0_q, cy0_q, dx0_q, dy0_q;

  // stage 1: differences and box test
  logic [DW-1:0] v1x1_q, v1y1_q, v2x1_q, v2y1_q, wx1_q, wy1_q;
  logic          box1_q;
  logic [C-1:0]  ax1_q, ay1_q;
  logic [DW-1:0] v1x1_d, v1y1_d, v2x1_d, v2y1_d, wx1_d, wy1_d;
  logic          box1_d;

  always_comb begin
    v1x1_d = {bx0_q[C-1], bx0_q} - {ax0_q[C-1], ax0_q};
    v1y1_d = {by0_q[C-1], by0_q} - {ay0_q[C-1], ay0_q};
    v2x1_d = {dx0_q[C-1], dx0_q} - {cx0_q[C-1], cx0_q};
    v2y1_d = {dy0_q[C-1], dy0_q} - {cy0_q[C-1], cy0_q};
    wx1_d  = {cx0_q[C-1], cx0_q} - {ax0_q[C-1], ax0_q};
    wy1_d  = {cy0_q[C-1], cy0_q} - {ay0_q[C-1], ay0_q};
  end

  // inclusive boxes are disjoint when one low end passes the other high end
  always_comb begin
    logic signed [C-1:0] lo1x, hi1x, lo2x, hi2x, lo1y, hi1y, lo2y, hi2y;
    lo1x = ($signed(ax0_q) < $signed(bx0_q)) ? ax0_q : bx0_q;
    hi1x = ($signed(ax0_q) < $signed(bx0_q)) ? bx0_q : ax0_q;
    lo2x = ($signed(cx0_q) < $signed(dx0_q)) ? cx0_q : dx0_q;
    hi2x = ($signed(cx0_q) < $signed(dx0_q)) ? dx0_q : cx0_q;
    lo1y = ($signed(ay0_q) < $signed(by0_q)) ? ay0_q : by0_q;
    hi1y = ($signed(ay0_q) < $signed(by0_q)) ? by0_q : ay0_q;
    lo2y = ($signed(cy0_q) < $signed(dy0_q)) ? cy0_q : dy0_q;
    hi2y = ($signed(cy0_q) < $signed(dy0_q)) ? dy0_q : cy0_q;
    box1_d = (lo1x > hi2x) || (lo2x > hi1x) || (lo1y > hi2y) || (lo2y > hi1y);
  end

  // stage 2: six products
  logic signed [PW-1:0] pa2_q, pb2_q, pc2_q, pd2_q, pe2_q, pf2_q;
  logic [DW-1:0]        v1x2_q, v1y2_q;
  logic                 box2_q;
  logic [C-1:0]         ax2_q, ay2_q;

  // stage 3: determinant and numerators
  logic signed [NW-1:0] den3_q, nt3_q, nu3_q;
  logic [DW-1:0]        v1x3_q, v1y3_q;
  logic                 box3_q;
  logic [C-1:0]         ax3_q, ay3_q;

  // stage 4: sign fix, range check, magnitudes
  logic [1:0]    oc4_q, oc4_d;
  logic [RW-1:0] den4_q, nt4_q;
  logic [C-1:0]  mx4_q, my4_q;
  logic          negx4_q, negy4_q;
  logic [C-1:0]  ax4_q, ay4_q;
  logic signed [NW-1:0] den4_d, nt4_d, nu4_d;
  logic [DW-1:0] mx4_d, my4_d;

  always_comb begin
    den4_d = den3_q[NW-1] ? -den3_q : den3_q;
    nt4_d  = den3_q[NW-1] ? -nt3_q  : nt3_q;
    nu4_d  = den3_q[NW-1] ? -nu3_q  : nu3_q;
    mx4_d  = v1x3_q[DW-1] ? -v1x3_q : v1x3_q;
    my4_d  = v1y3_q[DW-1] ? -v1y3_q : v1y3_q;
    if (box3_q) begin
      oc4_d = OUTC_BOX;
    end else if (den3_q == '0) begin
      oc4_d = OUTC_DET;
    end else if (nt4_d[NW-1] || (nt4_d > den4_d) || nu4_d[NW-1] || (nu4_d > den4_d)) begin
      oc4_d = OUTC_RANGE;
    end else begin
      oc4_d = OUTC_HIT;
    end
  end

  // stage 5: split multiply |v1| * nt
  logic [1:0]    oc5_q;
  logic [RW-1:0] den5_q;
  logic [LW-1:0] plx5_q, phx5_q, ply5_q, phy5_q;
  logic          negx5_q, negy5_q;
  logic [C-1:0]  ax5_q, ay5_q;

  // divider lanes, entry 0 is the dividend setup stage
  div_t       dv_q [Q+1];
  logic [MW-1:0] px6_d, py6_d;

  always_comb begin
    px6_d = {{(MW-LW){1'b0}}, plx5_q} + {phx5_q[MW-H-1:0], {H{1'b0}}};
    py6_d = {{(MW-LW){1'b0}}, ply5_q} + {phy5_q[MW-H-1:0], {H{1'b0}}};
  end

  // final stage: a nonzero remainder rounds the magnitude up only for a negative part
  logic          hit7_q;
  logic [1:0]    oc7_q;
  logic [OW-1:0] cx7_q, cy7_q;
  logic [OW-1:0] cx7_d, cy7_d;

  always_comb begin
    logic [Q:0]          pmx, pmy;
    logic signed [SW-1:0] ptx, pty, sx, sy;
    logic [SW+OW-1:0]    ex, ey;
    pmx = {1'b0, dv_q[Q].shx} +
          {{Q{1'b0}}, (dv_q[Q].negx && (dv_q[Q].remx != '0))};
    pmy = {1'b0, dv_q[Q].shy} +
          {{Q{1'b0}}, (dv_q[Q].negy && (dv_q[Q].remy != '0))};
    ptx = dv_q[Q].negx ? -$signed({1'b0, pmx}) : $signed({1'b0, pmx});
    pty = dv_q[Q].negy ? -$signed({1'b0, pmy}) : $signed({1'b0, pmy});
    sx  = $signed({{2{dv_q[Q].ax[C-1]}}, dv_q[Q].ax, {F{1'b0}}}) + ptx;
    sy  = $signed({{2{dv_q[Q].ay[C-1]}}, dv_q[Q].ay, {F{1'b0}}}) + pty;
    ex  = {{OW{sx[SW-1]}}, sx};
    ey  = {{OW{sy[SW-1]}}, sy};
    cx7_d = (dv_q[Q].outcome == OUTC_HIT) ? ex[OW-1:0] : '0;
    cy7_d = (dv_q[Q].outcome == OUTC_HIT) ? ey[OW-1:0] : '0;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      dv_v_q  <= '0;
      fin_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[4:0], in_valid_i};
      dv_v_q  <= {dv_v_q[Q-1:0], v_q[5]};
      fin_v_q <= dv_v_q[Q];
    end
  end

  // fixed stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax0_q <= seg1_start_x_i;
      ay0_q <= seg1_start_y_i;
      bx0_q <= seg1_end_x_i;
      by0_q <= seg1_end_y_i;
      cx0_q <= seg2_start_x_i;
      cy0_q <= seg2_start_y_i;
      dx0_q <= seg2_end_x_i;
      dy0_q <= seg2_end_y_i;

      v1x1_q <= v1x1_d;
      v1y1_q <= v1y1_d;
      v2x1_q <= v2x1_d;
      v2y1_q <= v2y1_d;
      wx1_q  <= wx1_d;
      wy1_q  <= wy1_d;
      box1_q <= box1_d;
      ax1_q  <= ax0_q;
      ay1_q  <= ay0_q;

      pa2_q  <= $signed(v1x1_q) * $signed(v2y1_q);
      pb2_q  <= $signed(v1y1_q) * $signed(v2x1_q);
      pc2_q  <= $signed(wx1_q) * $signed(v2y1_q);
      pd2_q  <= $signed(wy1_q) * $signed(v2x1_q);
      pe2_q  <= $signed(wx1_q) * $signed(v1y1_q);
      pf2_q  <= $signed(wy1_q) * $signed(v1x1_q);
      v1x2_q <= v1x1_q;
      v1y2_q <= v1y1_q;
      box2_q <= box1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;

      den3_q <= {pa2_q[PW-1], pa2_q} - {pb2_q[PW-1], pb2_q};
      nt3_q  <= {pc2_q[PW-1], pc2_q} - {pd2_q[PW-1], pd2_q};
      nu3_q  <= {pe2_q[PW-1], pe2_q} - {pf2_q[PW-1], pf2_q};
      v1x3_q <= v1x2_q;
      v1y3_q <= v1y2_q;
      box3_q <= box2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;

      oc4_q   <= oc4_d;
      den4_q  <= den4_d[RW-1:0];
      nt4_q   <= nt4_d[RW-1:0];
      mx4_q   <= mx4_d[C-1:0];
      my4_q   <= my4_d[C-1:0];
      negx4_q <= v1x3_q[DW-1];
      negy4_q <= v1y3_q[DW-1];
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;

      oc5_q   <= oc4_q;
      den5_q  <= den4_q;
      plx5_q  <= mx4_q * nt4_q[H-1:0];
      phx5_q  <= mx4_q * nt4_q[RW-1:H];
      ply5_q  <= my4_q * nt4_q[H-1:0];
      phy5_q  <= my4_q * nt4_q[RW-1:H];
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;

      // dividend is P << F; its top part P >> C is already below den
      dv_q[0].outcome <= oc5_q;
      dv_q[0].ax      <= ax5_q;
      dv_q[0].ay      <= ay5_q;
      dv_q[0].negx    <= negx5_q;
      dv_q[0].negy    <= negy5_q;
      dv_q[0].den     <= den5_q;
      dv_q[0].remx    <= px6_d[MW-1:C];
      dv_q[0].remy    <= py6_d[MW-1:C];
      dv_q[0].shx     <= {px6_d[C-1:0], {F{1'b0}}};
      dv_q[0].shy     <= {py6_d[C-1:0], {F{1'b0}}};

      hit7_q <= (dv_q[Q].outcome == OUTC_HIT);
      oc7_q  <= dv_q[Q].outcome;
      cx7_q  <= cx7_d;
      cy7_q  <= cy7_d;
    end
  end

  // one quotient bit per stage in each lane
  for (genvar k = 1; k <= Q; k++) begin : g_div
    logic [RW+Q-1:0] stx, sty;
    assign stx = div_step(dv_q[k-1].remx, dv_q[k-1].shx, dv_q[k-1].den);
    assign sty = div_step(dv_q[k-1].remy, dv_q[k-1].shy, dv_q[k-1].den);
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k].outcome <= dv_q[k-1].outcome;
        dv_q[k].ax      <= dv_q[k-1].ax;
        dv_q[k].ay      <= dv_q[k-1].ay;
        dv_q[k].negx    <= dv_q[k-1].negx;
        dv_q[k].negy    <= dv_q[k-1].negy;
        dv_q[k].den     <= dv_q[k-1].den;
        dv_q[k].remx    <= stx[RW+Q-1:Q];
        dv_q[k].shx     <= stx[Q-1:0];
        dv_q[k].remy    <= sty[RW+Q-1:Q];
        dv_q[k].shy     <= sty[Q-1:0];
      end
    end
  end

  // output register plus skid entry
  logic          pipe_out;
  logic          out_fire;
  logic          hit_q, skhit_q;
  logic [1:0]    oc_q, skoc_q;
  logic [OW-1:0] cx_q, cy_q, skcx_q, skcy_q;

  assign pipe_out = fin_v_q & en;
  assign out_fire = out_v_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (pipe_out) begin
      if (out_v_q && !out_fire) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        hit_q <= skhit_q;
        oc_q  <= skoc_q;
        cx_q  <= skcx_q;
        cy_q  <= skcy_q;
      end
    end else if (pipe_out) begin
      if (out_v_q && !out_fire) begin
        skhit_q <= hit7_q;
        skoc_q  <= oc7_q;
        skcx_q  <= cx7_q;
        skcy_q  <= cy7_q;
      end else begin
        hit_q <= hit7_q;
        oc_q  <= oc7_q;
        cx_q  <= cx7_q;
        cy_q  <= cy7_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign hit_o       = hit_q;
  assign outcome_o   = oc_q;
  assign cross_x_o   = cx_q;
  assign cross_y_o   = cy_q;

  // checks
  `SEGI_ASSERT_NOW(a_skid_needs_out, skid_v_q, out_v_q)
  `SEGI_ASSERT_NOW(a_miss_zero, out_v_q && !hit_o, cross_x_o == '0 && cross_y_o == '0)
  `SEGI_ASSERT_NOW(a_hit_code, out_v_q, hit_o == (outcome_o == OUTC_HIT))
  `SEGI_ASSERT_NEXT(a_skid_holds, skid_v_q && out_stall_i, skid_v_q && in_stall_o)

endmodule
`default_nettype wire

>>> bench/segment_intersection_2d_checker.sv
// Checker for the segment intersection block: watches both channels, predicts each
// result from the input beat and compares in order. Depends on segi2d_pkg.
`timescale 1ns / 1ps
module segment_intersection_2d_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] ax_i,
  input  logic [15:0] ay_i,
  input  logic [15:0] bx_i,
  input  logic [15:0] by_i,
  input  logic [15:0] cx_i,
  input  logic [15:0] cy_i,
  input  logic [15:0] dx_i,
  input  logic [15:0] dy_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        hit_i,
  input  logic [1:0]  outcome_i,
  input  logic [31:0] cross_x_i,
  input  logic [31:0] cross_y_i,
  output int          fail_count_o,
  output int          pending_o
);
  import segi2d_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [1:0]  outcome;
    logic [31:0] cx;
    logic [31:0] cy;
  } crossing_t;

  crossing_t crossing_q[$];

  // floor(a * n * 2^16 / den), n >= 0, den > 0; sizes fit in 128 bits
  function automatic logic signed [127:0] scaled_frac(longint a, longint n, longint den);
    logic signed [127:0] num;
    logic signed [127:0] d;
    logic signed [127:0] q;
    num = 128'(signed'(a)) * 128'(signed'(n));
    num = num <<< 16;
    d = 128'(signed'(den));
    q = num / d;
    if (num < 0 && q * d != num) q = q - 1;
    return q;
  endfunction

  function automatic crossing_t solve_pair(logic [15:0] ax16, logic [15:0] ay16,
                                           logic [15:0] bx16, logic [15:0] by16,
                                           logic [15:0] cx16, logic [15:0] cy16,
                                           logic [15:0] dx16, logic [15:0] dy16);
    crossing_t r;
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint v1x, v1y, v2x, v2y, wx, wy, den, nt, nu;
    logic signed [127:0] px, py;
    ax = longint'(signed'(ax16)); ay = longint'(signed'(ay16));
    bx = longint'(signed'(bx16)); by = longint'(signed'(by16));
    cx = longint'(signed'(cx16)); cy = longint'(signed'(cy16));
    dx = longint'(signed'(dx16)); dy = longint'(signed'(dy16));
    r = '0;
    // inclusive bounding box rejection, x then y
    if (((ax < bx ? ax : bx) > (cx < dx ? dx : cx)) ||
        ((cx < dx ? cx : dx) > (ax < bx ? bx : ax)) ||
        ((ay < by ? ay : by) > (cy < dy ? dy : cy)) ||
        ((cy < dy ? cy : dy) > (ay < by ? by : ay))) begin
      r.outcome = OUTC_BOX;
      return r;
    end
    v1x = bx - ax; v1y = by - ay;
    v2x = dx - cx; v2y = dy - cy;
    wx = cx - ax;  wy = cy - ay;
    den = v1x * v2y - v1y * v2x;
    nt = wx * v2y - wy * v2x;
    nu = wx * v1y - wy * v1x;
    if (den == 0) begin
      r.outcome = OUTC_DET;
      return r;
    end
    if (den < 0) begin
      den = -den; nt = -nt; nu = -nu;
    end
    if (nt < 0 || nt > den || nu < 0 || nu > den) begin
      r.outcome = OUTC_RANGE;
      return r;
    end
    px = scaled_frac(v1x, nt, den) + (128'(signed'(ax)) <<< 16);
    py = scaled_frac(v1y, nt, den) + (128'(signed'(ay)) <<< 16);
    r.hit = 1'b1;
    r.outcome = OUTC_HIT;
    r.cx = px[31:0];
    r.cy = py[31:0];
    return r;
  endfunction

  assign pending_o = crossing_q.size();

  // predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t want;
    if (!rst_ni) begin
      crossing_q.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        crossing_q.push_back(solve_pair(ax_i, ay_i, bx_i, by_i, cx_i, cy_i, dx_i, dy_i));
      if (out_valid_i && !out_stall_i) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: unexpected beat hit=%0d outcome=%0d x=%h y=%h", $time,
                   hit_i, outcome_i, cross_x_i, cross_y_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = crossing_q.pop_front();
          if (want !== {hit_i, outcome_i, cross_x_i, cross_y_i}) begin
            $display("%0t: expected hit=%0d outcome=%0d x=%h y=%h, got hit=%0d outcome=%0d x=%h y=%h",
                     $time, want.hit, want.outcome, want.cx, want.cy,
                     hit_i, outcome_i, cross_x_i, cross_y_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/segment_intersection_2d_top_tb.sv
// Testbench top for the segment intersection block: clock, reset, stimulus, verdict.
// Depends on segi2d_pkg, segment_intersection_2d_top and segment_intersection_2d_checker.
`timescale 1ns / 1ps
module segment_intersection_2d_top_tb;
  localparam int NUM_RANDOM = 1700;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] pt[8];
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [1:0]  outcome;
  logic [31:0] cross_x, cross_y;
  int          fail_count, pending, cycles;
  logic        stim_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial foreach (pt[k]) pt[k] = '0;

  segment_intersection_2d_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .seg1_start_x_i(pt[0]), .seg1_start_y_i(pt[1]),
    .seg1_end_x_i(pt[2]), .seg1_end_y_i(pt[3]),
    .seg2_start_x_i(pt[4]), .seg2_start_y_i(pt[5]),
    .seg2_end_x_i(pt[6]), .seg2_end_y_i(pt[7]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hit_o(hit), .outcome_o(outcome), .cross_x_o(cross_x), .cross_y_o(cross_y)
  );

  segment_intersection_2d_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .ax_i(pt[0]), .ay_i(pt[1]), .bx_i(pt[2]), .by_i(pt[3]),
    .cx_i(pt[4]), .cy_i(pt[5]), .dx_i(pt[6]), .dy_i(pt[7]),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .hit_i(hit), .outcome_i(outcome), .cross_x_i(cross_x), .cross_y_i(cross_y),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // no gap half the time, otherwise mostly short gaps and now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // one beat: hold valid until accepted, then maybe idle
  task automatic send_pair(input logic [15:0] p[8]);
    int n;
    for (int k = 0; k < 8; k++) pt[k] <= p[k];
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 40) - 20);
      default: return 16'($urandom_range(0, 1) ? 16'h7fff - $urandom_range(0, 3)
                                                : 16'h8000 + $urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    logic [15:0] p[8];
    logic [15:0] mx, mn;
    int mode;
    mx = 16'h7fff; mn = 16'h8000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: X crossing, extremes, touching ends, parallel, collinear, point, miss
    p = '{0, 0, 10, 10, 0, 10, 10, 0};            send_pair(p);
    p = '{mn, mn, mx, mx, mn, mx, mx, mn};        send_pair(p);
    p = '{mx, mn, mn, mx, mn, mn, mx, mx};        send_pair(p);
    p = '{0, 0, 3, 7, 3, 7, 9, -2};               send_pair(p);
    p = '{0, 0, 5, 0, 5, 0, 5, 5};                send_pair(p);
    p = '{0, 0, 4, 4, 1, 0, 5, 4};                send_pair(p);
    p = '{0, 0, 4, 4, 2, 2, 6, 6};                send_pair(p);
    p = '{2, 2, 2, 2, 0, 0, 4, 4};                send_pair(p);
    p = '{0, 0, 1, 1, 5, 5, 6, 7};                send_pair(p);
    p = '{0, 0, 1, 0, 0, 5, 1, 6};                send_pair(p);
    p = '{0, 0, 4, 4, 4, 0, 3, 2};                send_pair(p);
    p = '{-7, 3, 5, -4, -6, -5, 2, 8};            send_pair(p);
    p = '{0, 0, 3, 1, 1, 1, 2, -1};               send_pair(p);
    p = '{-3, 0, 0, -1, -2, 0, -1, -2};           send_pair(p);
    p = '{mx, mx, mx, mx, mx, mx, mx, mx};        send_pair(p);
    p = '{mn, 0, mx, 0, 0, mn, 0, mx};            send_pair(p);
    p = '{16'hffff, 16'hffff, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 0, 0};
    send_pair(p);

    // random: mix small-range (many hits), full range and near-extreme coords
    repeat (NUM_RANDOM) begin
      mode = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
      for (int k = 0; k < 8; k++) p[k] = rnd_coord(mode);
      if ($urandom_range(0, 9) == 0) begin
        p[4] = p[2]; p[5] = p[3];
      end
      send_pair(p);
    end
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // verdict and timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("segment_intersection_2d_top_tb: errors");
        $finish;
      end
      if (stim_done && pending == 0) begin
        repeat (60) @(posedge clk_i);
        if (fail_count == 0 && pending == 0)
          $display("segment_intersection_2d_top_tb: clean");
        else
          $display("segment_intersection_2d_top_tb: errors");
        $finish;
      end
    end
  end
endmodule
